// File: src/lcwt_pkg.sv
// Shared constants for the line and word tokenizer: byte codes, result kinds, phase codes.
package lcwt_pkg;

	localparam int unsigned LineCountBitsDef = 16;

	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChQuote = 8'h22;
	localparam logic [7:0] ChComma = 8'h2C;
	localparam logic [7:0] ChSemi  = 8'h3B;

	localparam logic [1:0] KindByte     = 2'd0;
	localparam logic [1:0] KindWordEnd  = 2'd1;
	localparam logic [1:0] KindLineEnd  = 2'd2;
	localparam logic [1:0] KindInputEnd = 2'd3;

	localparam logic [1:0] PhStart   = 2'd0;
	localparam logic [1:0] PhLine    = 2'd1;
	localparam logic [1:0] PhComment = 2'd2;

endpackage

// File: src/line_comment_word_tokenizer.sv
// Top level of the line and word tokenizer: input register, state update, result register.
//
// Usage: feed one text byte per word on the input channel (byte_valid / byte_stall,
// payload in_byte). A zero byte ends the input. Results leave on the output channel
// (tok_valid / tok_stall) with kind, out_byte, line_number and word_open: a word byte,
// an end of word, an end of line or the end of input. A byte may give no result at all
// (separators, quotes, comment lines, empty lines, the byte after a CR).
// A byte taken into the input register is processed against the tokenizer state by
// combinational logic and its result is loaded into the result register, which drives
// tok_valid; a stall can hold the byte in the input register in between.
// Throughput: one byte per cycle while the receiver does not stall, set by the state
// update between the input register and the result register; nothing else loops back.
// Stall: when the receiver stalls with a result pending, the pending result holds,
// the byte in the input register waits, and byte_stall rises only if that register
// is full; the input side keeps moving as long as the result register can drain.
// Reset (arst_n low): all control state clears, the line counter goes to all ones so
// the first line reads as line zero. The end-of-input byte returns the tokenizer state
// to the same values.
module line_comment_word_tokenizer #(
	parameter int unsigned LINE_COUNT_BITS = lcwt_pkg::LineCountBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  in_byte,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [15:0] line_number,
	output logic        word_open
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// tokenizer state
	logic [1:0]                 phase_q;
	logic                       skip_q;
	logic                       word_q;
	logic                       quote_q;
	logic [LINE_COUNT_BITS-1:0] cnt_q;

	// next state and result
	logic [1:0]                 phase_n;
	logic                       skip_n;
	logic                       word_n;
	logic                       quote_n;
	logic [LINE_COUNT_BITS-1:0] cnt_n;
	logic                       res_v;
	logic [1:0]                 res_kind;
	logic [7:0]                 res_byte;
	logic                       res_open;
	logic [LINE_COUNT_BITS+15:0] cnt_ext;

	logic advance;
	logic fire;
	logic is_eol;
	logic is_sep;
	logic at_start;
	logic wa;
	logic qm;

	// The result register can take a new value when empty or being drained.
	assign advance    = !tok_valid || !tok_stall;
	assign fire       = valid_s1 && advance;
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= in_byte;
		end
	end

	assign is_eol   = (byte_s1 == lcwt_pkg::ChLf) || (byte_s1 == lcwt_pkg::ChCr);
	assign is_sep   = (byte_s1 == lcwt_pkg::ChSpace) || (byte_s1 == lcwt_pkg::ChComma)
			|| (byte_s1 == lcwt_pkg::ChTab);
	// Anything but inside-a-line or comment counts as line start, the unused code too.
	assign at_start = (phase_q != lcwt_pkg::PhLine) && (phase_q != lcwt_pkg::PhComment);
	assign wa       = at_start ? 1'b0 : word_q;
	assign qm       = at_start ? 1'b0 : quote_q;

	always_comb begin
		phase_n  = phase_q;
		skip_n   = skip_q;
		word_n   = word_q;
		quote_n  = quote_q;
		cnt_n    = cnt_q;
		res_v    = 1'b0;
		res_kind = lcwt_pkg::KindByte;
		res_byte = 8'd0;
		res_open = 1'b0;
		if (byte_s1 == lcwt_pkg::ChNul) begin
			// end of input: report, then return to reset values
			res_v    = 1'b1;
			res_kind = lcwt_pkg::KindInputEnd;
			res_open = (phase_q == lcwt_pkg::PhLine) ? word_q : 1'b0;
			phase_n  = lcwt_pkg::PhStart;
			skip_n   = 1'b0;
			word_n   = 1'b0;
			quote_n  = 1'b0;
			cnt_n    = '1;
		end else if (skip_q) begin
			// drop the byte after a CR
			skip_n = 1'b0;
		end else if (phase_q == lcwt_pkg::PhComment) begin
			if (is_eol) begin
				skip_n  = (byte_s1 == lcwt_pkg::ChCr);
				phase_n = lcwt_pkg::PhStart;
			end
		end else begin
			if (at_start) begin
				cnt_n = cnt_q + 1'b1;
			end
			word_n  = wa;
			quote_n = qm;
			if (at_start && is_eol) begin
				// empty line
				skip_n  = (byte_s1 == lcwt_pkg::ChCr);
				phase_n = lcwt_pkg::PhStart;
			end else if (at_start && (byte_s1 == lcwt_pkg::ChSemi)) begin
				phase_n = lcwt_pkg::PhComment;
			end else begin
				phase_n = lcwt_pkg::PhLine;
				if (is_eol) begin
					res_v    = 1'b1;
					res_kind = lcwt_pkg::KindLineEnd;
					res_open = wa;
					skip_n   = (byte_s1 == lcwt_pkg::ChCr);
					phase_n  = lcwt_pkg::PhStart;
					word_n   = 1'b0;
					quote_n  = 1'b0;
				end else if (is_sep) begin
					if (qm) begin
						res_v    = 1'b1;
						res_byte = byte_s1;
						word_n   = 1'b1;
					end else if (wa) begin
						res_v    = 1'b1;
						res_kind = lcwt_pkg::KindWordEnd;
						word_n   = 1'b0;
						quote_n  = 1'b0;
					end
				end else if (byte_s1 == lcwt_pkg::ChQuote) begin
					quote_n = !qm;
				end else begin
					res_v    = 1'b1;
					res_byte = byte_s1;
					word_n   = 1'b1;
				end
			end
		end
	end

	// Report the counter as it stands after this byte's update, except at end of
	// input where the value before the return to reset is reported.
	assign cnt_ext = (byte_s1 == lcwt_pkg::ChNul) ? {16'd0, cnt_q} : {16'd0, cnt_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lcwt_pkg::PhStart;
			skip_q  <= 1'b0;
			word_q  <= 1'b0;
			quote_q <= 1'b0;
			cnt_q   <= '1;
		end else if (fire) begin
			phase_q <= phase_n;
			skip_q  <= skip_n;
			word_q  <= word_n;
			quote_q <= quote_n;
			cnt_q   <= cnt_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid <= 1'b0;
		end else if (advance) begin
			tok_valid <= fire && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_v) begin
			kind        <= res_kind;
			out_byte    <= res_byte;
			line_number <= cnt_ext[15:0];
			word_open   <= res_open;
		end
	end

endmodule
